// ----- hdl/csd_pkg.sv -----
// shared types, constants and helper functions for the candidate sorter
// depends on nothing; imported by csd_store, csd_ctrl and the top level
package csd_pkg;

  localparam int MAX_CANDIDATES = 16;
  localparam int AW = $clog2(MAX_CANDIDATES);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);

  // floor(5g/11) as (g * 5 * 187) >> 11, exact while 5g stays within 160
  localparam int GAP_MUL   = 5 * 187;
  localparam int GAP_SHIFT = 11;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic [15:0] centre_x;
    logic [15:0] centre_y;
    logic [15:0] module_size;
    logic [7:0]  hit_count;
    logic        final_item;
  } cand_req_t;

  typedef struct packed {
    logic [15:0] sorted_x;
    logic [15:0] sorted_y;
    logic [15:0] sorted_size;
    logic [7:0]  sorted_count;
    logic        end_of_list;
  } sorted_req_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] size;
    logic [7:0]  count;
  } cand_entry_t;

  typedef struct packed {
    logic        we;
    addr_t       waddr;
    cand_entry_t wdata;
    addr_t       raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    logic eol;
  } emit_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS_INIT,
    ST_CAP_HELD,
    ST_CMP,
    ST_PLACE,
    ST_SCAN_HEAD,
    ST_SCAN_CAP,
    ST_SCAN,
    ST_EMIT_CAP,
    ST_EMIT_WAIT
  } seq_state_t;

  function automatic cnt_t next_gap(input cnt_t g);
    logic [CW+9:0] prod;
    prod = (CW+10)'(g) * (CW+10)'(GAP_MUL);
    if (g == cnt_t'(2)) begin
      next_gap = cnt_t'(1);
    end else begin
      next_gap = cnt_t'(prod >> GAP_SHIFT);
    end
  endfunction

  function automatic logic [15:0] deviation(input logic [15:0] size, input logic [15:0] mean);
    deviation = (size >= mean) ? (size - mean) : (mean - size);
  endfunction

endpackage

// ----- hdl/csd_store.sv -----
// candidate store: one write port, one read port, registered read data
// uses csd_pkg; a read of the address written in the same cycle returns the new data
module csd_store (
  input  logic                clk,
  input  csd_pkg::mem_req_t   req,
  output csd_pkg::cand_entry_t rdata
);
  import csd_pkg::*;

  cand_entry_t mem [MAX_CANDIDATES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rdata <= req.wdata;
    end else begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- hdl/csd_ctrl.sv -----
// sequencer: loads candidates, runs the shell-sort passes over the store, emits
// uses csd_pkg; drives the csd_store ports and the output register strobe
module csd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cand_valid,
  output logic                 cand_stall,
  input  csd_pkg::cand_req_t   cand_req,
  input  logic [15:0]          mean,
  input  csd_pkg::cand_entry_t rdata,
  input  logic                 out_taken,
  output csd_pkg::mem_req_t    mem_req,
  output csd_pkg::emit_t       emit
);
  import csd_pkg::*;

  seq_state_t  state, state_next;
  cnt_t        n, n_next;
  cnt_t        base, base_next;
  cnt_t        len, len_next;
  cnt_t        g, g_next;
  cnt_t        i, i_next;
  cnt_t        j, j_next;
  logic        by_count, by_count_next;
  cand_entry_t held, held_next;
  logic [15:0] held_dev, held_dev_next;
  cnt_t        start, start_next;
  cnt_t        idx, idx_next;
  logic [7:0]  run_count, run_count_next;
  cnt_t        k, k_next;

  cnt_t n_load, half_len, i_inc, gap_nx, j_dn, idx_inc, k_inc, run_end, run_len;
  logic shift, do_place, pass_end, same_count;

  assign n_load     = (n < cnt_t'(MAX_CANDIDATES)) ? n + cnt_t'(1) : n;
  assign half_len   = len >> 1;
  assign i_inc      = i + cnt_t'(1);
  assign gap_nx     = next_gap(g);
  assign j_dn       = j - g;
  assign idx_inc    = idx + cnt_t'(1);
  assign k_inc      = k + cnt_t'(1);
  assign same_count = (rdata.count == run_count);
  assign run_end    = same_count ? n : idx;
  assign run_len    = run_end - start;
  assign shift      = by_count ? (rdata.count < held.count)
                               : (deviation(rdata.size, mean) > held_dev);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    base      <= base_next;
    len       <= len_next;
    g         <= g_next;
    i         <= i_next;
    j         <= j_next;
    by_count  <= by_count_next;
    held      <= held_next;
    held_dev  <= held_dev_next;
    start     <= start_next;
    idx       <= idx_next;
    run_count <= run_count_next;
    k         <= k_next;
  end

  always_comb begin
    state_next     = state;
    n_next         = n;
    base_next      = base;
    len_next       = len;
    g_next         = g;
    i_next         = i;
    j_next         = j;
    by_count_next  = by_count;
    held_next      = held;
    held_dev_next  = held_dev;
    start_next     = start;
    idx_next       = idx;
    run_count_next = run_count;
    k_next         = k;
    cand_stall     = 1'b1;
    mem_req.we     = 1'b0;
    mem_req.waddr  = '0;
    mem_req.wdata  = held;
    mem_req.raddr  = '0;
    emit.load      = 1'b0;
    emit.eol       = 1'b0;
    do_place       = 1'b0;
    pass_end       = 1'b0;

    unique case (state)
      ST_LOAD: begin
        cand_stall = 1'b0;
        if (cand_valid) begin
          if (n < cnt_t'(MAX_CANDIDATES)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = n[AW-1:0];
            mem_req.wdata = '{x: cand_req.centre_x, y: cand_req.centre_y,
                              size: cand_req.module_size, count: cand_req.hit_count};
          end
          n_next = n_load;
          if (cand_req.final_item) begin
            base_next     = '0;
            len_next      = n_load;
            by_count_next = 1'b1;
            state_next    = ST_PASS_INIT;
          end
        end
      end
      ST_PASS_INIT: begin
        if (half_len == '0) begin
          pass_end = 1'b1;
        end else begin
          g_next        = half_len;
          i_next        = half_len;
          mem_req.raddr = addr_t'(base + half_len);
          state_next    = ST_CAP_HELD;
        end
      end
      ST_CAP_HELD: begin
        held_next     = rdata;
        held_dev_next = deviation(rdata.size, mean);
        j_next        = i;
        mem_req.raddr = addr_t'(base + i - g);
        state_next    = ST_CMP;
      end
      ST_CMP: begin
        if (shift) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = addr_t'(base + j);
          mem_req.wdata = rdata;
          j_next        = j_dn;
          if (j_dn >= g) begin
            mem_req.raddr = addr_t'(base + j_dn - g);
          end else begin
            state_next = ST_PLACE;
          end
        end else begin
          do_place = 1'b1;
        end
      end
      ST_PLACE: begin
        do_place = 1'b1;
      end
      ST_SCAN_HEAD: begin
        if (start == n) begin
          k_next        = '0;
          mem_req.raddr = '0;
          state_next    = ST_EMIT_CAP;
        end else begin
          mem_req.raddr = start[AW-1:0];
          state_next    = ST_SCAN_CAP;
        end
      end
      ST_SCAN_CAP: begin
        run_count_next = rdata.count;
        if (start + cnt_t'(1) == n) begin
          start_next = n;
          state_next = ST_SCAN_HEAD;
        end else begin
          idx_next      = start + cnt_t'(1);
          mem_req.raddr = addr_t'(start + cnt_t'(1));
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (same_count && (idx_inc < n)) begin
          idx_next      = idx_inc;
          mem_req.raddr = idx_inc[AW-1:0];
        end else begin
          start_next = run_end;
          if (run_len > cnt_t'(1)) begin
            base_next     = start;
            len_next      = run_len;
            by_count_next = 1'b0;
            state_next    = ST_PASS_INIT;
          end else begin
            state_next = ST_SCAN_HEAD;
          end
        end
      end
      ST_EMIT_CAP: begin
        emit.load  = 1'b1;
        emit.eol   = (k_inc == n);
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_taken) begin
          if (k_inc == n) begin
            n_next     = '0;
            state_next = ST_LOAD;
          end else begin
            k_next        = k_inc;
            mem_req.raddr = k_inc[AW-1:0];
            state_next    = ST_EMIT_CAP;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase

    // drop the held entry into its slot and step to the next element or gap, or end the pass
    if (do_place) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = addr_t'(base + j);
      mem_req.wdata = held;
      if (i_inc < len) begin
        i_next        = i_inc;
        mem_req.raddr = addr_t'(base + i_inc);
        state_next    = ST_CAP_HELD;
      end else if (gap_nx == '0) begin
        pass_end = 1'b1;
      end else begin
        g_next        = gap_nx;
        i_next        = gap_nx;
        mem_req.raddr = addr_t'(base + gap_nx);
        state_next    = ST_CAP_HELD;
      end
    end

    if (pass_end) begin
      if (by_count) begin
        start_next = '0;
      end
      state_next = ST_SCAN_HEAD;
    end
  end

endmodule

// ----- hdl/candidate_sort_count_then_deviation_core.sv -----
// candidate sorter top level: mean size register, output register, store and sequencer
// uses csd_pkg, csd_store and csd_ctrl
//
// usage
//   candidates arrive on the cand channel (cand_valid / cand_stall / cand_req),
//   one request per candidate; the one carrying final_item closes the set
//   loading accepts one request per cycle; with the store full, further
//   candidates are dropped but a final one still starts the sort
//   after the final request the store is shell-sorted in place: first by hit
//   count (highest first), then each run of equal counts by the distance of
//   the module size from mean_module_size (smallest first)
//   each element of a pass is captured, compared with the entries a gap back and
//   shifted entry by entry, then placed, and a scan over the store finds the runs;
//   the single read port of the store reads each entry in turn
//   results leave on the sorted channel, one request per candidate, each loaded
//   only after the previous one is taken; end_of_list marks the last one
//   a stalled result holds in the output register; the sequencer waits
//   cand_stall stays high from the final request until the last result is taken
//   mean_module_size is written through cfg_write / cfg_data by the user, only while
//   idle (not enforced); synchronous reset empties the set and clears the mean to
//   zero; store contents are not cleared, only entries of the current set are read
module candidate_sort_count_then_deviation_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [15:0]           cfg_data,
  input  logic                  cand_valid,
  output logic                  cand_stall,
  input  csd_pkg::cand_req_t    cand_req,
  output logic                  sorted_valid,
  input  logic                  sorted_stall,
  output csd_pkg::sorted_req_t  sorted_req
);
  import csd_pkg::*;

  logic [15:0] mean_module_size;
  mem_req_t    mem_req;
  cand_entry_t rdata;
  emit_t       emit;
  logic        out_taken;

  // reference size for the secondary ordering
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_module_size <= '0;
    end else if (cfg_write) begin
      mean_module_size <= cfg_data;
    end
  end

  assign out_taken = sorted_valid && !sorted_stall;

  // output register, loaded straight from the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (emit.load) begin
      sorted_valid <= 1'b1;
    end else if (out_taken) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      sorted_req <= '{sorted_x: rdata.x, sorted_y: rdata.y, sorted_size: rdata.size,
                      sorted_count: rdata.count, end_of_list: emit.eol};
    end
  end

  csd_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  csd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand_req   (cand_req),
    .mean       (mean_module_size),
    .rdata      (rdata),
    .out_taken  (out_taken),
    .mem_req    (mem_req),
    .emit       (emit)
  );

  // after a candidate that does not close the set, the loader is open again in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (cand_valid && !cand_stall && !cand_req.final_item) |=> !cand_stall)
    else $error("loader stalled after a non-final candidate");

  // no result is pending while new candidates are taken
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !cand_stall |-> !sorted_valid)
    else $error("result pending while accepting candidates");

  // the last result hands the block back to loading
  a_eol_reopens: assert property (@(posedge clk) disable iff (rst)
    (sorted_valid && !sorted_stall && sorted_req.end_of_list) |=> !cand_stall)
    else $error("loader not reopened after end of list");

  // nothing is written to the store while a result waits
  a_no_write_on_wait: assert property (@(posedge clk) disable iff (rst)
    (sorted_valid && sorted_stall) |-> !mem_req.we)
    else $error("store written while a result is stalled");

endmodule

// ----- tb/sv/candidate_sort_count_then_deviation_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for the candidate sorter: directed sets then random sets
// under three idling mixes; expected order comes from a shell-sort predictor
// depends on csd_pkg and candidate_sort_count_then_deviation_core
module candidate_sort_count_then_deviation_core_tb;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;   // sequencer back to load after the last result
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off for the pressure phase
  localparam int SET_DEPTH     = csd_pkg::MAX_CANDIDATES;

  // one directed stimulus row; want is only meaningful where typed is set
  typedef struct {
    csd_pkg::cand_req_t   req;
    bit                   typed;
    csd_pkg::sorted_req_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [15:0]           cfg_data;
  logic                  cand_valid;
  logic                  cand_stall;
  csd_pkg::cand_req_t    cand_req;
  logic                  sorted_valid;
  logic                  sorted_stall;
  csd_pkg::sorted_req_t  sorted_req;

  // predictor state: the current set, its length and the mean size
  csd_pkg::cand_entry_t  set_buf [0:SET_DEPTH-1];
  int                    set_len;
  logic [15:0]           ref_mean;

  csd_pkg::sorted_req_t  sorted_batch [$];    // results of the latest request
  csd_pkg::sorted_req_t  expected_sorted [$]; // results still to arrive, oldest first
  stim_row_t             directed_rows [$];

  int                    mismatches;
  int                    cycle_count;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  bit                    hold_request;

  candidate_sort_count_then_deviation_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cand_valid   (cand_valid),
    .cand_stall   (cand_stall),
    .cand_req     (cand_req),
    .sorted_valid (sorted_valid),
    .sorted_stall (sorted_stall),
    .sorted_req   (sorted_req)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // absolute distance of a size from the mean, exact in Q12.4
  function automatic int size_offset(logic [15:0] s);
    int d;
    d = int'(s) - int'(ref_mean);
    return (d < 0) ? -d : d;
  endfunction

  // true when the earlier entry has to move up past the held one
  function automatic bit ranks_below(csd_pkg::cand_entry_t earlier,
                                     csd_pkg::cand_entry_t held, bit by_count);
    if (by_count) begin
      return earlier.count < held.count;
    end
    return size_offset(earlier.size) > size_offset(held.size);
  endfunction

  // gapped insertion sort over set_buf[base +: len]; gaps n/2, then 5g/11, 2 goes to 1
  task automatic gap_sort(input int base, input int len, input bit by_count);
    int g;
    int i;
    int j;
    csd_pkg::cand_entry_t held;
    g = len / 2;
    while (g > 0) begin
      for (i = 0; i < len; i++) begin
        j = i;
        held = set_buf[base + i];
        // short-circuit keeps the index in range once j drops below g
        while (j >= g && ranks_below(set_buf[base + j - g], held, by_count)) begin
          set_buf[base + j] = set_buf[base + j - g];
          j -= g;
        end
        set_buf[base + j] = held;
      end
      g = (g == 2) ? 1 : (5 * g) / 11;
    end
  endtask

  // loads one candidate; on the final one sorts the set and fills sorted_batch
  task automatic take_candidate(input csd_pkg::cand_req_t r);
    int k;
    int run_start;
    csd_pkg::sorted_req_t res;
    sorted_batch.delete();
    // a full store drops the candidate, but a final flag still closes the set
    if (set_len < SET_DEPTH) begin
      set_buf[set_len].x     = r.centre_x;
      set_buf[set_len].y     = r.centre_y;
      set_buf[set_len].size  = r.module_size;
      set_buf[set_len].count = r.hit_count;
      set_len++;
    end
    if (!r.final_item) begin
      return;
    end
    // primary order: hit count, highest first
    gap_sort(0, set_len, 1'b1);
    // secondary order inside each run of equal counts: nearest to the mean first
    run_start = 0;
    for (k = 1; k <= set_len; k++) begin
      if (k == set_len || set_buf[k].count != set_buf[run_start].count) begin
        if (k - run_start > 1) begin
          gap_sort(run_start, k - run_start, 1'b0);
        end
        run_start = k;
      end
    end
    for (k = 0; k < set_len; k++) begin
      res.sorted_x     = set_buf[k].x;
      res.sorted_y     = set_buf[k].y;
      res.sorted_size  = set_buf[k].size;
      res.sorted_count = set_buf[k].count;
      res.end_of_list  = (k == set_len - 1);
      sorted_batch.push_back(res);
    end
    set_len = 0;
  endtask

  function automatic bit roll_pct(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // offers one request from a falling edge and returns at the falling edge after
  // acceptance; valid stays high into the next request unless an idle gap follows
  task automatic offer_cand(input csd_pkg::cand_req_t r, input bit typed,
                            input csd_pkg::sorted_req_t want);
    int k;
    while (roll_pct(send_idle_pct)) begin
      cand_valid = 1'b0;
      @(negedge clk);
    end
    cand_valid = 1'b1;
    cand_req   = r;
    do @(posedge clk); while (cand_stall);
    take_candidate(r);
    // typed rows carry their expectation; the predictor keeps its state regardless
    if (typed) begin
      expected_sorted.push_back(want);
    end else begin
      for (k = 0; k < sorted_batch.size(); k++) begin
        expected_sorted.push_back(sorted_batch[k]);
      end
    end
    @(negedge clk);
  endtask

  // drain: every expected result in, then let the sequencer come back to load
  task automatic settle_idle;
    cand_valid = 1'b0;
    while (expected_sorted.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mean(input logic [15:0] value);
    cfg_data  = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    ref_mean  = value;
  endtask

  task automatic add_row(input logic [15:0] x, input logic [15:0] y,
                         input logic [15:0] size, input logic [7:0] count,
                         input bit fin, input bit typed, input csd_pkg::sorted_req_t want);
    stim_row_t row;
    row.req.centre_x    = x;
    row.req.centre_y    = y;
    row.req.module_size = size;
    row.req.hit_count   = count;
    row.req.final_item  = fin;
    row.typed           = typed;
    row.want            = want;
    directed_rows.push_back(row);
  endtask

  // random sets: mostly short, some up to the store depth, a few that overflow it
  task automatic random_sets(input int item_goal);
    int sent;
    int len;
    int k;
    int style;
    bit narrow;
    logic [7:0] run_base;
    csd_pkg::cand_req_t r;
    sent = 0;
    while (sent < item_goal) begin
      style    = $urandom_range(0, 99);
      len      = (style < 75) ? $urandom_range(1, 8) :
                 (style < 92) ? $urandom_range(9, 16) : $urandom_range(17, 20);
      narrow   = $urandom_range(0, 2) != 0;
      run_base = 8'($urandom);
      for (k = 0; k < len; k++) begin
        r.centre_x    = 16'($urandom);
        r.centre_y    = 16'($urandom);
        // narrow counts give long runs of ties for the secondary pass
        r.hit_count   = narrow ? run_base + 8'($urandom_range(0, 2)) : 8'($urandom);
        // sizes near the mean give equal and near-equal distances on both sides
        r.module_size = roll_pct(50) ? ref_mean + 16'($urandom_range(0, 48)) - 16'd24
                                     : 16'($urandom);
        r.final_item  = (k == len - 1);
        offer_cand(r, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: random stall per mix, or one long hold-off when asked
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    sorted_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        sorted_stall = 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        sorted_stall = 1'b1;
      end else begin
        sorted_stall = roll_pct(recv_idle_pct);
      end
    end
  end

  // compare each accepted result, field by field, with the oldest expectation
  always @(posedge clk) begin : result_check
    csd_pkg::sorted_req_t want;
    if (!rst && sorted_valid && !sorted_stall) begin
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, sorted_req);
        mismatches++;
      end else begin
        want = expected_sorted.pop_front();
        if (sorted_req.sorted_x !== want.sorted_x) begin
          $display("%0t: sorted_x expected %h got %h", $time, want.sorted_x,
                   sorted_req.sorted_x);
          mismatches++;
        end
        if (sorted_req.sorted_y !== want.sorted_y) begin
          $display("%0t: sorted_y expected %h got %h", $time, want.sorted_y,
                   sorted_req.sorted_y);
          mismatches++;
        end
        if (sorted_req.sorted_size !== want.sorted_size) begin
          $display("%0t: sorted_size expected %h got %h", $time, want.sorted_size,
                   sorted_req.sorted_size);
          mismatches++;
        end
        if (sorted_req.sorted_count !== want.sorted_count) begin
          $display("%0t: sorted_count expected %h got %h", $time, want.sorted_count,
                   sorted_req.sorted_count);
          mismatches++;
        end
        if (sorted_req.end_of_list !== want.end_of_list) begin
          $display("%0t: end_of_list expected %b got %b", $time, want.end_of_list,
                   sorted_req.end_of_list);
          mismatches++;
        end
      end
    end
  end

  // watchdog over the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("candidate_sort_count_then_deviation_core: mismatch");
      $finish;
    end
  end

  initial begin : main
    int k;
    int full_counts [0:16];
    int full_sizes [0:16];
    csd_pkg::sorted_req_t want;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    cand_valid    = 1'b0;
    cand_req      = '0;
    mismatches    = 0;
    cycle_count   = 0;
    set_len       = 0;
    ref_mean      = '0;
    hold_request  = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 79;

    // single candidates come back unchanged with end_of_list set
    want = {16'h1234, 16'h5678, 16'h0320, 8'd5, 1'b1};
    add_row(16'h1234, 16'h5678, 16'h0320, 8'd5, 1'b1, 1'b1, want);
    want = {16'h0000, 16'h0000, 16'h0000, 8'd0, 1'b1};
    add_row(16'h0000, 16'h0000, 16'h0000, 8'd0, 1'b1, 1'b1, want);
    want = {16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1};
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, want);
    // one run of equal counts: distances tie above and below the mean, plus both ends
    add_row(16'h0010, 16'h0020, 16'h0330, 8'd7, 1'b0, 1'b0, '0);
    add_row(16'h0011, 16'h0021, 16'h0310, 8'd7, 1'b0, 1'b0, '0);
    add_row(16'h0012, 16'h0022, 16'h0320, 8'd7, 1'b0, 1'b0, '0);
    add_row(16'h0013, 16'h0023, 16'h0000, 8'd7, 1'b0, 1'b0, '0);
    add_row(16'h0014, 16'h0024, 16'hFFFF, 8'd7, 1'b1, 1'b0, '0);
    // a full store and one more: the extra candidate is dropped, its final flag still sorts
    full_counts = '{9, 255, 9, 0, 1, 255, 9, 0, 4, 4, 255, 1, 9, 0, 200, 9, 255};
    full_sizes  = '{'h0320, 'h0000, 'h0340, 'hFFFF, 'h0300, 'h0320, 'h0300, 'h0321,
                    'h031F, 'h0320, 'hFFFF, 'h0001, 'h0340, 'h0320, 'h8000, 'h0320,
                    'h0320};
    for (k = 0; k <= SET_DEPTH; k++) begin
      add_row(16'(k * 'h0101), 16'(16'hF000 - k), 16'(full_sizes[k]),
              8'(full_counts[k]), k == SET_DEPTH, 1'b0, '0);
    end

    // reset held from the start, released on a falling edge
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed rows: sender 29 and receiver 79 in a hundred
    write_mean(16'h0320);
    for (k = 0; k < directed_rows.size(); k++) begin
      offer_cand(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    end
    settle_idle();

    // random sets, same mix, mean at its top
    write_mean(16'hFFFF);
    random_sets(25);
    settle_idle();

    // mix swapped, mean at zero
    send_idle_pct = 79;
    recv_idle_pct = 29;
    write_mean(16'h0000);
    random_sets(25);
    settle_idle();

    // no idling; the receiver opens with a long hold-off so that the block
    // fills, holds its results and stalls further requests
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mean(16'($urandom));
    hold_request = 1'b1;
    random_sets(25);
    settle_idle();

    if (mismatches == 0) begin
      $display("candidate_sort_count_then_deviation_core: match");
    end else begin
      $display("candidate_sort_count_then_deviation_core: mismatch");
    end
    $finish;
  end

endmodule
